[sv/rtpm_pkg.sv]
// Shared constants, types and helper functions of the rotating target plate matcher.
package rtpm_pkg;

    // Number of nearest plates that compete in the selection, clamped to the plate count
    localparam int CANDIDATES = 3;
    localparam int CAND_N     = (CANDIDATES < 1) ? 1 : ((CANDIDATES > 4) ? 4 : CANDIDATES);

    localparam int STEPS   = 14;
    localparam int LATENCY = 35;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [17:0] QUARTER  = 18'sd16384;
    localparam logic signed [17:0] HALF     = 18'sd32768;

    localparam logic [13:0] ATAN_TAB [STEPS] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163,
        14'd81, 14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1
    };

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] mpose;
        logic signed [15:0] mbear;
    } ang_t;

    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [24:0] cz;
        logic signed [24:0] hz;
        logic signed [24:0] r0;
        logic signed [24:0] r1;
        logic               neg;
    } geo_t;

    // Round a Q30 product half up to integer units
    function automatic logic signed [26:0] round_q30(input logic signed [58:0] p);
        logic signed [58:0] t;
        begin
            t = p + 59'sd536870912;
            return t[56:30];
        end
    endfunction

    // Absolute wrapped difference of two binary angles, 0..32768
    function automatic logic [16:0] abs_wrap(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        logic [16:0] e;
        begin
            d = a - b;
            e = {d[15], d};
            return e[16] ? (17'd0 - e) : e;
        end
    endfunction

endpackage

[sv/rotating_target_plate_matcher.sv]
// Top level of the rotating target plate matcher: a fully pipelined plate classifier.
//
// Usage:
//   Drive the target geometry and the measured plate angles and raise start for one
//   cycle per item. busy is tied low: a new item is taken in every cycle.
//   Each item yields one plate_index, shown for exactly one cycle with done high.
//   Each item passes through capture, 14 sin/cos CORDIC steps, unfold, multiply,
//   position, squares, range sum and ranking beside the four parallel 14-step
//   atan2 CORDICs, score, then the registered selection.
//   Throughput: one item per cycle.
//   Results leave in the order the items came in.
//   Reset clears all valid bits; items in flight are dropped, and no strobe
//   appears until a new item has passed through the full pipeline.
//   The receiver cannot stall: every result must be taken in its cycle.
//   Positions are signed 1/4096 m, angles are 16-bit binary angles.
//   Nearest plates are ranked by squared range, ties to the lower index; the
//   best score among the nearest candidates wins, ties to the earlier rank.
module rotating_target_plate_matcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [23:0]  center_x,
    input  logic signed [23:0]  center_y,
    input  logic signed [23:0]  center_z,
    input  logic signed [15:0]  body_yaw,
    input  logic signed [23:0]  base_radius,
    input  logic signed [23:0]  radius_extra,
    input  logic signed [23:0]  height_extra,
    input  logic signed [15:0]  meas_pose_yaw,
    input  logic signed [15:0]  meas_bearing,
    output logic                done,
    output logic [1:0]          plate_index
);
    import rtpm_pkg::*;

    // valid bits, one per stage
    logic               v_reg [0:33];

    // payload carried along the pipe
    ang_t               ang_reg [0:32];
    geo_t               geo_reg [0:16];

    // sin/cos rotation CORDIC
    logic signed [33:0] rx_reg [0:14];
    logic signed [33:0] ry_reg [0:14];
    logic signed [17:0] rz_reg [0:14];
    logic signed [33:0] rx_next [1:14];
    logic signed [33:0] ry_next [1:14];
    logic signed [17:0] rz_next [1:14];
    logic signed [17:0] z_fold;
    logic               neg_fold;

    logic signed [33:0] c_reg;
    logic signed [33:0] s_reg;

    logic signed [58:0] p_r0c_reg;
    logic signed [58:0] p_r0s_reg;
    logic signed [58:0] p_r1c_reg;
    logic signed [58:0] p_r1s_reg;

    logic signed [26:0] px_reg [0:3];
    logic signed [26:0] py_reg [0:3];
    logic signed [26:0] pz_reg [0:3];

    logic [53:0]        sq_reg [0:3][0:2];
    logic [55:0]        d_reg [0:3];
    logic [1:0]         rank_next [0:3];
    logic [1:0]         rk_reg [0:12][0:3];

    // atan2 vectoring CORDICs, one per plate
    logic signed [49:0] ax_reg [0:3][0:14];
    logic signed [49:0] ay_reg [0:3][0:14];
    logic signed [17:0] az_reg [0:3][0:14];
    logic               zf_reg [0:3][0:14];
    logic signed [49:0] ax_next [0:3][1:14];
    logic signed [49:0] ay_next [0:3][1:14];
    logic signed [17:0] az_next [0:3][1:14];
    logic signed [49:0] ax_init [0:3];
    logic signed [49:0] ay_init [0:3];
    logic signed [17:0] az_init [0:3];

    logic [16:0]        score_reg [0:3];
    logic [1:0]         srank_reg [0:3];
    logic [3:0]         win;
    logic [1:0]         win_idx;
    logic [3:0]         rank_cover;

    assign busy = 1'b0;

    // Fold the yaw into the right half plane
    always_comb
    begin
        z_fold   = 18'(body_yaw);
        neg_fold = 1'b0;
        if (z_fold > QUARTER)
        begin
            z_fold   = z_fold - HALF;
            neg_fold = 1'b1;
        end
        else if (z_fold < -QUARTER)
        begin
            z_fold   = z_fold + HALF;
            neg_fold = 1'b1;
        end
    end

    // Rotation micro-steps, one per stage
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (!rz_reg[k][17])
            begin
                rx_next[k+1] = rx_reg[k] - (ry_reg[k] >>> k);
                ry_next[k+1] = ry_reg[k] + (rx_reg[k] >>> k);
                rz_next[k+1] = rz_reg[k] - $signed({4'b0, ATAN_TAB[k]});
            end
            else
            begin
                rx_next[k+1] = rx_reg[k] + (ry_reg[k] >>> k);
                ry_next[k+1] = ry_reg[k] - (rx_reg[k] >>> k);
                rz_next[k+1] = rz_reg[k] + $signed({4'b0, ATAN_TAB[k]});
            end
        end
    end

    // Turn vectors with negative x by a quarter turn before vectoring
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            logic signed [49:0] x0;
            logic signed [49:0] y0;
            x0 = 50'(px_reg[p]) <<< 20;
            y0 = 50'(py_reg[p]) <<< 20;
            ax_init[p] = x0;
            ay_init[p] = y0;
            az_init[p] = 18'sd0;
            if (x0[49])
            begin
                if (!y0[49])
                begin
                    ax_init[p] = y0;
                    ay_init[p] = -x0;
                    az_init[p] = QUARTER;
                end
                else
                begin
                    ax_init[p] = -y0;
                    ay_init[p] = x0;
                    az_init[p] = -QUARTER;
                end
            end
        end
    end

    // Vectoring micro-steps, one per stage and plate
    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                if (ay_reg[p][k] > 50'sd0)
                begin
                    ax_next[p][k+1] = ax_reg[p][k] + (ay_reg[p][k] >>> k);
                    ay_next[p][k+1] = ay_reg[p][k] - (ax_reg[p][k] >>> k);
                    az_next[p][k+1] = az_reg[p][k] + $signed({4'b0, ATAN_TAB[k]});
                end
                else
                begin
                    ax_next[p][k+1] = ax_reg[p][k] - (ay_reg[p][k] >>> k);
                    ay_next[p][k+1] = ay_reg[p][k] + (ax_reg[p][k] >>> k);
                    az_next[p][k+1] = az_reg[p][k] - $signed({4'b0, ATAN_TAB[k]});
                end
            end
        end
    end

    // Rank plates by squared range, ties to the lower index
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [2:0] cnt;
            cnt = 3'd0;
            for (int j = 0; j < 4; j++)
            begin
                if ((d_reg[j] < d_reg[i]) || ((d_reg[j] == d_reg[i]) && (j < i)))
                begin
                    cnt = cnt + 3'd1;
                end
            end
            rank_next[i] = cnt[1:0];
        end
    end

    // Pick the best scoring candidate, ties to the earlier rank
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic ok;
            ok = ({1'b0, srank_reg[i]} < 3'(CAND_N));
            for (int j = 0; j < 4; j++)
            begin
                if ((j != i) && ({1'b0, srank_reg[j]} < 3'(CAND_N)))
                begin
                    if (!((score_reg[i] < score_reg[j]) ||
                          ((score_reg[i] == score_reg[j]) &&
                           (srank_reg[i] < srank_reg[j]))))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            win[i] = ok;
        end
        win_idx = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (win[i])
            begin
                win_idx = 2'(i);
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 34; s++)
            begin
                v_reg[s] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            v_reg[0] <= start;
            for (int s = 1; s < 34; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
            done <= v_reg[33];
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        // capture the item and set up the rotation
        ang_reg[0].yaw   <= body_yaw;
        ang_reg[0].mpose <= meas_pose_yaw;
        ang_reg[0].mbear <= meas_bearing;
        geo_reg[0].cx    <= center_x;
        geo_reg[0].cy    <= center_y;
        geo_reg[0].cz    <= 25'(center_z);
        geo_reg[0].hz    <= 25'(center_z) + 25'(height_extra);
        geo_reg[0].r0    <= 25'(base_radius);
        geo_reg[0].r1    <= 25'(base_radius) + 25'(radius_extra);
        geo_reg[0].neg   <= neg_fold;
        rx_reg[0]        <= CORDIC_K;
        ry_reg[0]        <= 34'sd0;
        rz_reg[0]        <= z_fold;

        for (int s = 1; s < 33; s++)
        begin
            ang_reg[s] <= ang_reg[s-1];
        end
        for (int s = 1; s < 17; s++)
        begin
            geo_reg[s] <= geo_reg[s-1];
        end
        for (int k = 1; k < 15; k++)
        begin
            rx_reg[k] <= rx_next[k];
            ry_reg[k] <= ry_next[k];
            rz_reg[k] <= rz_next[k];
        end

        // undo the half-turn fold
        c_reg <= geo_reg[14].neg ? -rx_reg[14] : rx_reg[14];
        s_reg <= geo_reg[14].neg ? -ry_reg[14] : ry_reg[14];

        // scale the unit vector by both radii
        p_r0c_reg <= 59'(geo_reg[15].r0) * 59'(c_reg);
        p_r0s_reg <= 59'(geo_reg[15].r0) * 59'(s_reg);
        p_r1c_reg <= 59'(geo_reg[15].r1) * 59'(c_reg);
        p_r1s_reg <= 59'(geo_reg[15].r1) * 59'(s_reg);

        // plate positions
        px_reg[0] <= 27'(geo_reg[16].cx) - round_q30(p_r0c_reg);
        py_reg[0] <= 27'(geo_reg[16].cy) - round_q30(p_r0s_reg);
        px_reg[1] <= 27'(geo_reg[16].cx) - round_q30(-p_r1s_reg);
        py_reg[1] <= 27'(geo_reg[16].cy) - round_q30(p_r1c_reg);
        px_reg[2] <= 27'(geo_reg[16].cx) - round_q30(-p_r0c_reg);
        py_reg[2] <= 27'(geo_reg[16].cy) - round_q30(-p_r0s_reg);
        px_reg[3] <= 27'(geo_reg[16].cx) - round_q30(p_r1s_reg);
        py_reg[3] <= 27'(geo_reg[16].cy) - round_q30(-p_r1c_reg);
        pz_reg[0] <= 27'(geo_reg[16].cz);
        pz_reg[1] <= 27'(geo_reg[16].hz);
        pz_reg[2] <= 27'(geo_reg[16].cz);
        pz_reg[3] <= 27'(geo_reg[16].hz);

        for (int p = 0; p < 4; p++)
        begin
            // squares, then range sum
            sq_reg[p][0] <= 54'(54'(px_reg[p]) * 54'(px_reg[p]));
            sq_reg[p][1] <= 54'(54'(py_reg[p]) * 54'(py_reg[p]));
            sq_reg[p][2] <= 54'(54'(pz_reg[p]) * 54'(pz_reg[p]));
            d_reg[p]     <= 56'(sq_reg[p][0]) + 56'(sq_reg[p][1]) + 56'(sq_reg[p][2]);

            // hold the ranks until the bearings are ready
            rk_reg[0][p] <= rank_next[p];
            for (int s = 1; s < 13; s++)
            begin
                rk_reg[s][p] <= rk_reg[s-1][p];
            end

            // bearing CORDIC
            ax_reg[p][0] <= ax_init[p];
            ay_reg[p][0] <= ay_init[p];
            az_reg[p][0] <= az_init[p];
            zf_reg[p][0] <= (px_reg[p] == 27'sd0) && (py_reg[p] == 27'sd0);
            for (int k = 1; k < 15; k++)
            begin
                ax_reg[p][k] <= ax_next[p][k];
                ay_reg[p][k] <= ay_next[p][k];
                az_reg[p][k] <= az_next[p][k];
                zf_reg[p][k] <= zf_reg[p][k-1];
            end

            // score against the measured pose yaw and bearing
            score_reg[p] <= abs_wrap(ang_reg[32].mpose,
                                     ang_reg[32].yaw + {2'(p), 14'd0})
                          + abs_wrap(ang_reg[32].mbear,
                                     zf_reg[p][14] ? 16'd0 : az_reg[p][14][15:0]);
            srank_reg[p] <= rk_reg[12][p];
        end

        plate_index <= win_idx;
    end

    always_comb
    begin
        rank_cover = 4'd0;
        for (int i = 0; i < 4; i++)
        begin
            rank_cover = rank_cover | (4'd1 << rank_next[i]);
        end
    end

    // Every taken item yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##35 done)
        else $error("result missing after fixed latency");

    // No result without an item taken at the matching earlier edge
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching item");

    // Ranks form a permutation of the four plates
    a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[19] |-> (rank_cover == 4'hF))
        else $error("plate ranks are not a permutation");

    // Exactly one plate wins the selection
    a_one_winner: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[33] |-> $onehot(win))
        else $error("selection did not give a single winner");

endmodule
